// File: rtl/devicenet_frame_classifier_unit_defines.svh
// Assertion macros shared by the DeviceNet frame classifier RTL.
`ifndef DEVICENET_FRAME_CLASSIFIER_UNIT_DEFINES_SVH
`define DEVICENET_FRAME_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DNFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dnfc_pkg.sv
// Types, constants and the identifier decode function of the DeviceNet frame classifier.
package dnfc_pkg;

    localparam logic [10:0] G1_MAX      = 11'h3FF;
    localparam logic [10:0] G2_MAX      = 11'h5FF;
    localparam logic [10:0] G3_MAX      = 11'h7BF;
    localparam logic [10:0] G4_MAX      = 11'h7EF;
    localparam logic [6:0]  SVC_NET_LO  = 7'h4B;
    localparam logic [6:0]  SVC_NET_HI  = 7'h4E;
    localparam logic [5:0]  G4_FIRST    = 6'h2C;
    localparam logic [6:0]  LEN_DUP     = 7'd7;
    localparam logic [6:0]  LEN_HDR     = 7'd1;
    localparam logic [6:0]  LEN_SVC     = 7'd2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;

    typedef enum logic [2:0] {
        GRP_NONE = 3'd0,
        GRP_1    = 3'd1,
        GRP_2    = 3'd2,
        GRP_3    = 3'd3,
        GRP_4    = 3'd4
    } group_t;

    typedef enum logic [2:0] {
        DET_NONE    = 3'd0,
        DET_DUP_MAC = 3'd1,
        DET_G3_HDR  = 3'd2,
        DET_G3_FRAG = 3'd3,
        DET_G3_SVC  = 3'd4
    } detail_t;

    typedef enum logic [2:0] {
        G3K_GENERIC = 3'd0,
        G3K_RESP    = 3'd1,
        G3K_REQ     = 3'd2,
        G3K_INVALID = 3'd3
    } g3_kind_t;

    typedef struct packed {
        logic [55:0] payload_head;
        logic [6:0]  payload_len;
        logic        fd_frame;
        logic        error_frame;
        logic        remote_frame;
        logic        ext_frame;
        logic [10:0] frame_id;
    } frame_t;

    typedef struct packed {
        logic        network_specific_service;
        logic [31:0] serial_number;
        logic [15:0] vendor_id;
        logic [6:0]  low_seven;
        logic        response_flag;
        logic        xid_flag;
        logic [5:0]  dest_mac;
        logic [2:0]  detail_kind;
        logic [5:0]  source_mac;
        logic [2:0]  message_kind;
        logic [2:0]  group;
        logic        accepted;
    } result_t;

    function automatic result_t decode(frame_t f);
        result_t    r;
        logic [10:0] id;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        pay_ok;
        r      = '0;
        id     = f.frame_id;
        b0     = f.payload_head[7:0];
        b1     = f.payload_head[15:8];
        pay_ok = !f.fd_frame;
        if (!(f.ext_frame || f.remote_frame || f.error_frame)) begin
            r.accepted = 1'b1;
            if (id <= G1_MAX) begin
                r.group      = GRP_1;
                r.source_mac = id[5:0];
                if (id[9:8] == 2'b11) begin
                    r.message_kind = {1'b0, id[7:6]} + 3'd1;
                end
            end else if (id <= G2_MAX) begin
                r.group        = GRP_2;
                r.message_kind = id[2:0];
                r.source_mac   = id[8:3];
                if (id[2:0] == 3'd7 && pay_ok && f.payload_len >= LEN_DUP) begin
                    r.detail_kind   = DET_DUP_MAC;
                    r.response_flag = b0[7];
                    r.low_seven     = b0[6:0];
                    r.vendor_id     = f.payload_head[23:8];
                    r.serial_number = f.payload_head[55:24];
                end
            end else if (id <= G3_MAX) begin
                r.group      = GRP_3;
                r.source_mac = id[5:0];
                case (id[8:6])
                    3'd5:    r.message_kind = G3K_RESP;
                    3'd6:    r.message_kind = G3K_REQ;
                    3'd7:    r.message_kind = G3K_INVALID;
                    default: r.message_kind = G3K_GENERIC;
                endcase
                if (pay_ok && f.payload_len >= LEN_HDR) begin
                    r.dest_mac = b0[5:0];
                    r.xid_flag = b0[6];
                    if (b0[7]) begin
                        r.detail_kind = DET_G3_FRAG;
                    end else if (f.payload_len >= LEN_SVC) begin
                        r.detail_kind   = DET_G3_SVC;
                        r.response_flag = b1[7];
                        r.low_seven     = b1[6:0];
                        r.network_specific_service =
                            (b1[6:0] >= SVC_NET_LO) && (b1[6:0] <= SVC_NET_HI);
                    end else begin
                        r.detail_kind = DET_G3_HDR;
                    end
                end
            end else if (id <= G4_MAX) begin
                r.group = GRP_4;
                if (id[5:2] == G4_FIRST[5:2]) begin
                    r.message_kind = {1'b0, id[1:0]} + 3'd1;
                end
            end else begin
                r.group = GRP_NONE;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/devicenet_frame_classifier_unit.sv
// Top level of the DeviceNet frame classifier: input register, decode, result register.
//
// Input stream (s_axis): one beat carries one received CAN frame. tdata holds the
// identifier, payload length and payload bytes 0..6; tuser holds the frame flags.
// Result stream (m_axis): one beat per input beat, in the same order. tuser bit 0
// is the accepted flag; tdata holds the group, kinds, MAC IDs and unpacked payload.
// Extended, remote and error frames produce a result with accepted low and all
// other fields zero.
// A beat is held in the input register, then the decode of its frame is registered into
// the result register, from which the result is presented. Throughput is one beat
// per cycle while the receiver keeps m_axis_tready high.
// When the receiver holds m_axis_tready low, the result register holds its beat,
// the input register fills behind it, and s_axis_tready drops only when both
// are occupied; no beat is lost or repeated.
// Reset (aresetn low at a rising edge) empties both registers; s_axis_tready is
// high again in the first cycle after reset.
`include "devicenet_frame_classifier_unit_defines.svh"

module devicenet_frame_classifier_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // frame_id[10:0], payload_len[17:11], payload_head[73:18], zero fill
    input  logic [dnfc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // ext_frame[0], remote_frame[1], error_frame[2], fd_frame[3]
    input  logic [dnfc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // group[2:0], message_kind[5:3], source_mac[11:6], detail_kind[14:12],
    // dest_mac[20:15], xid_flag[21], response_flag[22], low_seven[29:23],
    // vendor_id[45:30], serial_number[77:46], network_specific_service[78], zero fill
    output logic [dnfc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // accepted[0]
    output logic [0:0]                       m_axis_tuser
);

    logic               in_valid_reg;
    logic               in_valid_next;
    dnfc_pkg::frame_t   in_frame_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    dnfc_pkg::result_t  out_res_reg;
    dnfc_pkg::result_t  dec_res;
    logic               advance;
    logic               s_fire;

    // The result register takes a new beat when it is empty or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign dec_res = dnfc_pkg::decode(in_frame_reg);

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_frame_reg.frame_id     <= s_axis_tdata[10:0];
            in_frame_reg.payload_len  <= s_axis_tdata[17:11];
            in_frame_reg.payload_head <= s_axis_tdata[73:18];
            in_frame_reg.ext_frame    <= s_axis_tuser[0];
            in_frame_reg.remote_frame <= s_axis_tuser[1];
            in_frame_reg.error_frame  <= s_axis_tuser[2];
            in_frame_reg.fd_frame     <= s_axis_tuser[3];
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.accepted;
    assign m_axis_tdata  = {1'b0, out_res_reg[$bits(dnfc_pkg::result_t)-1:1]};

    `DNFC_ASSERT_IMP(a_reject_zero, aclk, aresetn,
        m_axis_tvalid && !out_res_reg.accepted, m_axis_tdata == '0,
        "rejected frame carries nonzero fields")
    `DNFC_ASSERT_IMP(a_detail_group, aclk, aresetn,
        m_axis_tvalid && out_res_reg.detail_kind != dnfc_pkg::DET_NONE,
        out_res_reg.group == dnfc_pkg::GRP_2 || out_res_reg.group == dnfc_pkg::GRP_3,
        "payload detail outside groups 2 and 3")
    `DNFC_ASSERT_IMP(a_g4_no_mac, aclk, aresetn,
        m_axis_tvalid && (out_res_reg.group == dnfc_pkg::GRP_4 ||
                          out_res_reg.group == dnfc_pkg::GRP_NONE),
        out_res_reg.source_mac == 6'd0,
        "source MAC set for group 4 or unclassified frame")
    `DNFC_ASSERT_NXT(a_in_capture, aclk, aresetn,
        s_fire, in_valid_reg,
        "accepted beat not held in input register")

endmodule
